// ----- design/ldf_pkg.sv -----
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared constants and types for the 6LoWPAN datagram fragmenter.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int ADDR_BITS_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0]  UNCOMP_DISPATCH = 8'h41;
  localparam logic [7:0]  HEAD_FRAG_MARK  = 8'hC0;
  localparam logic [7:0]  NEXT_FRAG_MARK  = 8'hE0;

  localparam logic [6:0]  BUDGET_RESET    = 7'd102;
  localparam logic [6:0]  BUDGET_MIN      = 7'd16;
  localparam logic [6:0]  FIRST_HDR_BYTES = 7'd4;
  localparam logic [6:0]  NEXT_HDR_BYTES  = 7'd5;
  localparam logic [6:0]  FRAG_ALIGN_MASK = 7'b111_1000;

  localparam logic [10:0] LEN_MIN = 11'd1;
  localparam logic [10:0] LEN_MAX = 11'd2046;

  localparam logic [2:0]  HDR_FIRST_LEN = 3'd4;
  localparam logic [2:0]  HDR_NEXT_LEN  = 3'd5;
  localparam logic [2:0]  HDR_NONE_LEN  = 3'd0;

  localparam logic [2:0]  HDR_IDX_MARK    = 3'd0;
  localparam logic [2:0]  HDR_IDX_SIZE_LO = 3'd1;
  localparam logic [2:0]  HDR_IDX_TAG_HI  = 3'd2;
  localparam logic [2:0]  HDR_IDX_TAG_LO  = 3'd3;
  localparam logic [2:0]  HDR_IDX_OFFSET  = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        dispatch;
    logic        hdr_first;
    logic        hdr_next;
    logic [10:0] size;
    logic [15:0] tag;
    logic [7:0]  offset;
    logic        frame_end;
    logic        packet_end;
  } cmd_t;

endpackage

// ----- design/ldf_if.sv -----
// ----------------------------------------------------------------------------
// ldf_in_if / ldf_out_if
// Valid/ready request channels for packet bytes and frame bytes.
// ----------------------------------------------------------------------------
interface ldf_in_if #(
  parameter int ADDR_BITS = ldf_pkg::ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [7:0]           data_byte;
  logic [10:0]          packet_len;
  logic [ADDR_BITS-1:0] dest_addr;

  modport source (output valid, data_byte, packet_len, dest_addr, input ready);
  modport sink   (input valid, data_byte, packet_len, dest_addr, output ready);
endinterface

interface ldf_out_if #(
  parameter int ADDR_BITS = ldf_pkg::ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic [ADDR_BITS-1:0] frame_dest;
  logic                 frame_end;
  logic                 packet_end;

  modport source (output valid, out_byte, frame_dest, frame_end, packet_end, input ready);
  modport sink   (input valid, out_byte, frame_dest, frame_end, packet_end, output ready);
endinterface

// ----- design/ldf_front.sv -----
// ----------------------------------------------------------------------------
// ldf_front
// Accepts packet bytes, tracks datagram state and frame boundaries, and
// issues one emit command per byte.
// ----------------------------------------------------------------------------
module ldf_front #(
  parameter int ADDR_BITS = ldf_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata,
  ldf_in_if.sink               in_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output ldf_pkg::cmd_t        q_cmd,
  output logic [ADDR_BITS-1:0] q_dest
);

  logic [6:0]           budget_r;
  logic [15:0]          tag_r, tag_nxt;
  logic [10:0]          size_r;
  logic [10:0]          pos_r;
  logic [6:0]           fill_r, fill_nxt;
  logic                 frag_r;
  logic                 first_r;
  logic [ADDR_BITS-1:0] dest_r, dest_nxt;

  logic [6:0]  b_eff;
  logic [10:0] len, s, p, p1, start, rem, cap, cap_first, cap_next;
  logic [6:0]  f, f1;
  logic        fr, hdr_next, pend, fend;

  always_comb begin
    b_eff = (budget_r < ldf_pkg::BUDGET_MIN) ? ldf_pkg::BUDGET_MIN : budget_r;
    priority if (in_ch.packet_len < ldf_pkg::LEN_MIN) begin
      len = ldf_pkg::LEN_MIN;
    end else if (in_ch.packet_len > ldf_pkg::LEN_MAX) begin
      len = ldf_pkg::LEN_MAX;
    end else begin
      len = in_ch.packet_len;
    end
    s        = first_r ? (len + 11'd1) : size_r;
    fr       = first_r ? (s > {4'b0, b_eff}) : frag_r;
    p        = first_r ? 11'd1 : pos_r;
    f        = first_r ? 7'd1 : fill_r;
    dest_nxt = first_r ? in_ch.dest_addr : dest_r;
    hdr_next = !first_r && fr && (f == 7'd0) && (p != 11'd0);
    p1       = p + 11'd1;
    f1       = f + 7'd1;
    pend     = (p1 >= s);
    start    = (p1 >= {4'b0, f1}) ? (p1 - {4'b0, f1}) : 11'd0;
    rem      = s - start;
    cap_first = {4'b0, (b_eff - ldf_pkg::FIRST_HDR_BYTES) & ldf_pkg::FRAG_ALIGN_MASK};
    cap_next  = {4'b0, (b_eff - ldf_pkg::NEXT_HDR_BYTES) & ldf_pkg::FRAG_ALIGN_MASK};
    priority if (start == 11'd0) begin
      cap = cap_first;
    end else if (rem > {4'b0, b_eff - ldf_pkg::NEXT_HDR_BYTES}) begin
      cap = cap_next;
    end else begin
      cap = rem;
    end
    fend     = pend || (fr && ({4'b0, f1} >= cap));
    fill_nxt = fend ? 7'd0 : f1;
    tag_nxt  = pend ? (tag_r + 16'd1) : tag_r;
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_dest      = dest_nxt;

  always_comb begin
    q_cmd.data_byte  = in_ch.data_byte;
    q_cmd.dispatch   = first_r;
    q_cmd.hdr_first  = first_r && fr;
    q_cmd.hdr_next   = hdr_next;
    q_cmd.size       = s;
    q_cmd.tag        = tag_r;
    q_cmd.offset     = p[10:3];
    q_cmd.frame_end  = fend;
    q_cmd.packet_end = pend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= ldf_pkg::BUDGET_RESET;
      tag_r    <= '0;
      size_r   <= '0;
      pos_r    <= '0;
      fill_r   <= '0;
      frag_r   <= 1'b0;
      first_r  <= 1'b1;
    end else begin
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
      if (q_push) begin
        tag_r   <= tag_nxt;
        size_r  <= s;
        pos_r   <= p1;
        fill_r  <= fill_nxt;
        frag_r  <= fr;
        first_r <= pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      dest_r <= dest_nxt;
    end
  end

endmodule

// ----- design/ldf_queue.sv -----
// ----------------------------------------------------------------------------
// ldf_queue
// Small register FIFO holding emit commands between front and back.
// ----------------------------------------------------------------------------
module ldf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ldf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- design/ldf_back.sv -----
// ----------------------------------------------------------------------------
// ldf_back
// Expands each emit command into header, dispatch and payload bytes and
// drives the registered output channel.
// ----------------------------------------------------------------------------
module ldf_back #(
  parameter int ADDR_BITS = ldf_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ldf_pkg::cmd_t        q_cmd,
  input  logic [ADDR_BITS-1:0] q_dest,
  output logic                 q_pop,
  ldf_out_if.source            out_ch
);

  logic [2:0]           k_r;
  logic                 valid_r;
  logic [7:0]           byte_r;
  logic [ADDR_BITS-1:0] dest_r;
  logic                 fend_r, pend_r;

  logic [2:0] hdr_len, last_idx;
  logic       last, load;
  logic [7:0] byte_nxt;
  logic [7:0] mark;

  always_comb begin
    priority if (q_cmd.hdr_first) begin
      hdr_len = ldf_pkg::HDR_FIRST_LEN;
    end else if (q_cmd.hdr_next) begin
      hdr_len = ldf_pkg::HDR_NEXT_LEN;
    end else begin
      hdr_len = ldf_pkg::HDR_NONE_LEN;
    end
    last_idx = hdr_len + {2'b0, q_cmd.dispatch};
    last     = (k_r == last_idx);
    load     = q_valid && (!valid_r || out_ch.ready);
    mark     = q_cmd.hdr_first ? ldf_pkg::HEAD_FRAG_MARK : ldf_pkg::NEXT_FRAG_MARK;
    priority if (k_r < hdr_len) begin
      unique case (k_r)
        ldf_pkg::HDR_IDX_MARK:    byte_nxt = mark | {5'b0, q_cmd.size[10:8]};
        ldf_pkg::HDR_IDX_SIZE_LO: byte_nxt = q_cmd.size[7:0];
        ldf_pkg::HDR_IDX_TAG_HI:  byte_nxt = q_cmd.tag[15:8];
        ldf_pkg::HDR_IDX_TAG_LO:  byte_nxt = q_cmd.tag[7:0];
        default:                  byte_nxt = q_cmd.offset;
      endcase
    end else if (q_cmd.dispatch && (k_r == hdr_len)) begin
      byte_nxt = ldf_pkg::UNCOMP_DISPATCH;
    end else begin
      byte_nxt = q_cmd.data_byte;
    end
  end

  assign q_pop = load && last;

  assign out_ch.valid      = valid_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.frame_dest = dest_r;
  assign out_ch.frame_end  = fend_r;
  assign out_ch.packet_end = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        k_r     <= last ? 3'd0 : k_r + 3'd1;
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      dest_r <= q_dest;
      fend_r <= last && q_cmd.frame_end;
      pend_r <= last && q_cmd.packet_end;
    end
  end

endmodule

// ----- design/lowpan_datagram_fragmenter_top.sv -----
// ----------------------------------------------------------------------------
// lowpan_datagram_fragmenter_top
// 6LoWPAN fragmentation of IPv6 packets into link frames.
// An accepted request is written into the queue, then loaded into the
// output register. Throughput: one byte per cycle while out_ch.ready is high;
// a byte opening a fragment takes six output bytes (header bytes included).
// Reset (rst_n low, synchronous): queue emptied, tag zero, budget 102,
// block waits for the first byte of a packet.
// ----------------------------------------------------------------------------
module lowpan_datagram_fragmenter_top #(
  parameter int ADDR_BITS = ldf_pkg::ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  ldf_in_if.sink     in_ch,
  ldf_out_if.source  out_ch
);

  localparam int CMD_W = $bits(ldf_pkg::cmd_t);
  localparam int Q_W   = CMD_W + ADDR_BITS;

  logic                 q_push, q_full, q_pop, q_valid;
  ldf_pkg::cmd_t        fr_cmd, bk_cmd;
  logic [ADDR_BITS-1:0] fr_dest, bk_dest;
  logic [Q_W-1:0]       q_rdata;

  ldf_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (fr_cmd),
    .q_dest    (fr_dest)
  );

  ldf_queue #(.WIDTH(Q_W), .DEPTH(ldf_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({fr_cmd, fr_dest}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign bk_cmd  = q_rdata[Q_W-1:ADDR_BITS];
  assign bk_dest = q_rdata[ADDR_BITS-1:0];

  ldf_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (bk_cmd),
    .q_dest  (bk_dest),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
